// ===== hw/rtl/mst_pkg.sv =====
// package for the multi-slot software timer unit
// holds command codes, payload structs, queue entry type and fsm states
package mst_pkg;

  localparam int unsigned SlotsDefault    = 16;
  localparam logic [15:0] MinSleepReset   = 16'd100;
  localparam logic [15:0] MaxSleepReset   = 16'd1000;
  localparam int unsigned CmdQueueDepth   = 2;

  typedef enum logic [1:0] {
    CmdSet  = 2'd0,
    CmdStop = 2'd1,
    CmdTick = 2'd2,
    CmdBad  = 2'd3
  } cmd_e;

  typedef enum logic {
    CfgMinSleep = 1'b0,
    CfgMaxSleep = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] timer_key;
    logic [31:0] countdown_usec;
    logic [31:0] interval_usec;
    logic [7:0]  queue_id;
    logic [31:0] message;
    logic [63:0] now_usec;
  } in_word_t;

  typedef struct packed {
    logic        status;
    logic        fired;
    logic [7:0]  fired_queue;
    logic [31:0] fired_message;
    logic [15:0] sleep_usec;
    logic        last;
  } out_word_t;

  // classified command as it leaves the front part
  typedef struct packed {
    cmd_e        op;
    logic        null_key;
    logic [15:0] timer_key;
    logic [63:0] due;
    logic [31:0] interval_usec;
    logic [7:0]  queue_id;
    logic [31:0] message;
    logic [63:0] now_usec;
  } job_t;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StApply,
    StTick,
    StSleep,
    StDone
  } state_e;

endpackage

// ===== hw/rtl/mst_front.sv =====
// front part: accepts commands, precomputes due time, feeds a small job queue
// depends on mst_pkg
module mst_front #(
  parameter int unsigned Depth = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  mst_pkg::in_word_t in_word_i,
  output logic              busy_o,
  output logic              job_valid_o,
  output mst_pkg::job_t     job_o,
  input  logic              job_pop_i
);
  import mst_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  job_t             mem_q [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [PtrW:0]    cnt_q;
  logic             push;
  job_t             job_new;

  assign busy_o      = (cnt_q == (PtrW+1)'(Depth));
  assign push        = start_i && !busy_o;
  assign job_valid_o = (cnt_q != '0);
  assign job_o       = mem_q[rd_q];

  // classify and precompute the due time
  always_comb begin
    job_new               = '0;
    job_new.op            = cmd_e'(in_word_i.cmd);
    job_new.null_key      = (in_word_i.timer_key == '0);
    job_new.timer_key     = in_word_i.timer_key;
    job_new.due           = in_word_i.now_usec + {32'd0, in_word_i.countdown_usec};
    job_new.interval_usec = in_word_i.interval_usec;
    job_new.queue_id      = in_word_i.queue_id;
    job_new.message       = in_word_i.message;
    job_new.now_usec      = in_word_i.now_usec;
  end

  // job storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= job_new;
    end
  end

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PtrW'(Depth-1)) ? '0 : wr_q + 1'b1;
      end
      if (job_pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth-1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(job_pop_i);
    end
  end

endmodule

// ===== hw/rtl/mst_back.sv =====
// back part: slot table and sequencer that scans slots one per cycle
// depends on mst_pkg
module mst_back #(
  parameter int unsigned Slots = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  input  mst_pkg::job_t      job_i,
  output logic               job_pop_o,
  input  logic [15:0]        min_sleep_i,
  input  logic [15:0]        max_sleep_i,
  output logic               result_valid_o,
  output mst_pkg::out_word_t result_o
);
  import mst_pkg::*;

  localparam int unsigned IdxW = (Slots > 1) ? $clog2(Slots) : 1;

  logic [Slots-1:0] valid_q, valid_d;
  logic [15:0]      key_q   [Slots];
  logic [7:0]       queue_q [Slots];
  logic [31:0]      msg_q   [Slots];
  logic [63:0]      due_q   [Slots];
  logic [31:0]      intv_q  [Slots];

  state_e           state_q, state_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic             hit_q, hit_d, free_q, free_d;
  logic [IdxW-1:0]  hit_idx_q, hit_idx_d, free_idx_q, free_idx_d;
  logic [15:0]      sleep_q, sleep_d;
  logic             wr_en, wr_due_only;
  logic [IdxW-1:0]  wr_idx;
  logic [63:0]      wr_due;
  logic             res_v_d, res_v_q;
  out_word_t        res_d, res_q;
  logic             idx_end;
  logic             due_now;
  logic [63:0]      remain;
  logic [15:0]      remain_c;

  assign idx_end        = (idx_q == IdxW'(Slots-1));
  assign due_now        = valid_q[idx_q] && (due_q[idx_q] <= job_i.now_usec);
  assign remain         = (due_q[idx_q] > job_i.now_usec) ? due_q[idx_q] - job_i.now_usec
                                                          : 64'd0;
  assign remain_c       = (remain[63:16] != '0) ? 16'hFFFF : remain[15:0];
  assign result_valid_o = res_v_q;
  assign result_o       = res_q;

  // sequencer
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    hit_d       = hit_q;
    free_d      = free_q;
    hit_idx_d   = hit_idx_q;
    free_idx_d  = free_idx_q;
    sleep_d     = sleep_q;
    valid_d     = valid_q;
    wr_en       = 1'b0;
    wr_due_only = 1'b0;
    wr_idx      = idx_q;
    wr_due      = job_i.due;
    res_v_d     = 1'b0;
    res_d       = '0;
    job_pop_o   = 1'b0;
    case (state_q)
      StIdle: begin
        idx_d  = '0;
        hit_d  = 1'b0;
        free_d = 1'b0;
        sleep_d = max_sleep_i;
        if (job_valid_i) begin
          if (job_i.op == CmdTick) begin
            state_d = StTick;
          end else if ((job_i.op == CmdSet || job_i.op == CmdStop) && !job_i.null_key) begin
            state_d = StScan;
          end else begin
            res_v_d      = 1'b1;
            res_d.status = 1'b1;
            res_d.last   = 1'b1;
            job_pop_o    = 1'b1;
          end
        end
      end
      StScan: begin
        if (valid_q[idx_q] && key_q[idx_q] == job_i.timer_key && !hit_q) begin
          hit_d     = 1'b1;
          hit_idx_d = idx_q;
        end
        if (!valid_q[idx_q] && !free_q) begin
          free_d     = 1'b1;
          free_idx_d = idx_q;
        end
        idx_d = idx_q + 1'b1;
        if (idx_end) begin
          idx_d   = '0;
          state_d = StApply;
        end
      end
      StApply: begin
        res_v_d    = 1'b1;
        res_d.last = 1'b1;
        job_pop_o  = 1'b1;
        state_d    = StIdle;
        if (job_i.op == CmdStop) begin
          res_d.status = !hit_q;
          if (hit_q) begin
            valid_d[hit_idx_q] = 1'b0;
          end
        end else begin
          res_d.status = !(hit_q || free_q);
          wr_idx       = hit_q ? hit_idx_q : free_idx_q;
          if (hit_q || free_q) begin
            wr_en           = 1'b1;
            valid_d[wr_idx] = 1'b1;
          end
        end
      end
      StTick: begin
        // expire pass, one slot per cycle
        if (due_now) begin
          if (queue_q[idx_q] != '0) begin
            res_v_d             = 1'b1;
            res_d.fired         = 1'b1;
            res_d.fired_queue   = queue_q[idx_q];
            res_d.fired_message = msg_q[idx_q];
          end
          if (intv_q[idx_q] != '0) begin
            wr_due_only = 1'b1;
            wr_due      = job_i.now_usec + {32'd0, intv_q[idx_q]};
          end else begin
            valid_d[idx_q] = 1'b0;
          end
        end
        idx_d = idx_q + 1'b1;
        if (idx_end) begin
          idx_d   = '0;
          state_d = StSleep;
        end
      end
      StSleep: begin
        // minimum pass over updated slots
        if (valid_q[idx_q] && remain_c < sleep_q) begin
          sleep_d = remain_c;
        end
        idx_d = idx_q + 1'b1;
        if (idx_end) begin
          idx_d   = '0;
          state_d = StDone;
        end
      end
      StDone: begin
        res_v_d    = 1'b1;
        res_d.last = 1'b1;
        res_d.sleep_usec = (sleep_q < min_sleep_i)
                           ? ((min_sleep_i > max_sleep_i) ? max_sleep_i : min_sleep_i)
                           : ((sleep_q > max_sleep_i) ? max_sleep_i : sleep_q);
        job_pop_o  = 1'b1;
        state_d    = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      idx_q      <= '0;
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
      hit_idx_q  <= '0;
      free_idx_q <= '0;
      sleep_q    <= '0;
      valid_q    <= '0;
      res_v_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      hit_q      <= hit_d;
      free_q     <= free_d;
      hit_idx_q  <= hit_idx_d;
      free_idx_q <= free_idx_d;
      sleep_q    <= sleep_d;
      valid_q    <= valid_d;
      res_v_q    <= res_v_d;
    end
  end

  // slot payload and result word
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (wr_en) begin
      key_q[wr_idx]   <= job_i.timer_key;
      queue_q[wr_idx] <= job_i.queue_id;
      msg_q[wr_idx]   <= job_i.message;
      intv_q[wr_idx]  <= job_i.interval_usec;
    end
    if (wr_en || wr_due_only) begin
      due_q[wr_idx] <= wr_due;
    end
  end

endmodule

// ===== hw/rtl/multi_slot_software_timer_unit.sv =====
// multi-slot software timer: front queue, back slot sequencer, config regs
// throughput: one command in work at a time; a scan visits one slot per cycle
// fired words of a tick come one per due slot with a nonzero queue id during the expire pass
// reset clears all slots and loads min_sleep 100, max_sleep 1000
// the receiver cannot stall; results go out on result_valid_o for one cycle
module multi_slot_software_timer_unit #(
  parameter int unsigned Slots = mst_pkg::SlotsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  mst_pkg::in_word_t  in_word_i,
  output logic               result_valid_o,
  output mst_pkg::out_word_t result_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [15:0]        cfg_data_i
);
  import mst_pkg::*;

  logic        job_valid, job_pop;
  job_t        job;
  logic [15:0] min_sleep_q, max_sleep_q;

  assign cfg_ready_o = 1'b1;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_sleep_q <= MinSleepReset;
      max_sleep_q <= MaxSleepReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgMinSleep) begin
        min_sleep_q <= cfg_data_i;
      end else begin
        max_sleep_q <= cfg_data_i;
      end
    end
  end

  mst_front #(.Depth(CmdQueueDepth)) u_front (
    .clk_i, .rst_ni,
    .start_i     (start),
    .in_word_i,
    .busy_o      (busy),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_pop_i   (job_pop)
  );

  mst_back #(.Slots(Slots)) u_back (
    .clk_i, .rst_ni,
    .job_valid_i    (job_valid),
    .job_i          (job),
    .job_pop_o      (job_pop),
    .min_sleep_i    (min_sleep_q),
    .max_sleep_i    (max_sleep_q),
    .result_valid_o,
    .result_o
  );

endmodule

// ===== hw/rtl/mst_checker.sv =====
// port checker for the timer unit, bound to the top level
// depends on mst_pkg
module mst_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               result_valid_o,
  input mst_pkg::out_word_t result_o
);
  // a fired word never closes an item
  a_fired_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.fired |-> !result_o.last) else $error("fired last");
  // fired words always succeed
  a_fired_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.fired |-> !result_o.status) else $error("fired status");
  // sleep only on a closing success word
  a_sleep_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.sleep_usec != '0 |-> result_o.last && !result_o.fired)
    else $error("sleep placement");
  // no output right after reset release
  a_quiet_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !result_valid_o) else $error("result out of reset");
endmodule

bind multi_slot_software_timer_unit mst_checker u_mst_checker (
  .clk_i, .rst_ni, .result_valid_o, .result_o
);
